// ----- sv/sfd_pkg.sv -----
package sfd_pkg;

	// Ring geometry.
	localparam int RING_DEPTH_DEF = 32;
	localparam int FRAME_SPAN     = 24;

	// Frame layout.
	localparam logic [7:0] START_MARK = 8'h0F;
	localparam logic [7:0] END_MARK   = 8'h00;
	localparam int NUM_CH      = 16;
	localparam int CH_W        = 11;
	localparam int CH_IDX_W    = 4;
	localparam int PAYLOAD_W   = NUM_CH * CH_W;
	localparam int FS_BYTE     = 23;
	localparam int BYTE_CNT_W  = 5;

	// Input field widths.
	localparam int BYTE_W  = 8;
	localparam int TICKS_W = 16;
	localparam int STAMP_W = 8;
	localparam int STAMP_LSB = 5;

	// Channel arithmetic.
	localparam int SCALE_W = 18;
	localparam int GAP_W   = 8;
	localparam int PROD_W  = CH_W + SCALE_W;
	localparam int FRAC_W  = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 18;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 4'd3;

	// Register values after reset.
	localparam logic [GAP_W-1:0]   GAP_RST    = 8'd4;
	localparam logic [CH_W-1:0]    OFFSET_RST = 11'd172;
	localparam logic [SCALE_W-1:0] SCALE_RST  = 18'd81800;
	localparam logic [CH_W-1:0]    MAX_RST    = 11'd2047;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDADDR,
		ST_RDDATA,
		ST_MUL,
		ST_SEND
	} sfd_state_t;

endpackage

// ----- sv/sfd_ram.sv -----
module sfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/sbus_frame_decoder_core.sv -----
// Channel   Signals                                      Beat
// -------   -------------------------------------------  -----------------------------------
// input     in_valid, in_stall, rx_byte, rx_error,        one received byte
//           arrival_ticks
// output    out_valid, out_stall, channel_index,          one decoded channel
//           channel_value, failsafe, last
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     one register write
//
// A plain byte or an errored byte is taken without a stall. An end mark stalls the input
// while its start slot is read back and checked. When it ends a frame the input stays
// stalled while the 24 ring slots are read through the one RAM read port (address and data
// steps alternate), then while each channel passes the shared multiplier and send step,
// plus any output stall met before the last channel is loaded.
// After reset the byte ring reads as 0xFF through per-slot valid bits; no clearing pass.
module sbus_frame_decoder_core #(
	parameter int RING_DEPTH = sfd_pkg::RING_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sfd_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                             rx_error,
	input  logic [sfd_pkg::TICKS_W-1:0]      arrival_ticks,
	// Output channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sfd_pkg::CH_IDX_W-1:0]     channel_index,
	output logic [sfd_pkg::CH_W-1:0]         channel_value,
	output logic                             failsafe,
	output logic                             last,
	// Configuration channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW     = $clog2(RING_DEPTH);
	localparam int RAM_W  = sfd_pkg::BYTE_W + sfd_pkg::STAMP_W;
	localparam int FRAC_SH = sfd_pkg::FRAC_W;
	localparam logic [AW-1:0] TOP_ADDR  = AW'(RING_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_W   = (AW+1)'(RING_DEPTH);
	localparam logic [AW:0]   SPAN_W    = (AW+1)'(sfd_pkg::FRAME_SPAN);
	localparam logic [sfd_pkg::BYTE_CNT_W-1:0] FS_CNT =
		sfd_pkg::BYTE_CNT_W'(sfd_pkg::FS_BYTE);
	localparam logic [sfd_pkg::CH_IDX_W-1:0] LAST_CH =
		sfd_pkg::CH_IDX_W'(sfd_pkg::NUM_CH - 1);

	sfd_pkg::sfd_state_t state_q, state_d;

	// Configuration registers.
	logic [sfd_pkg::GAP_W-1:0]   gap_q;
	logic [sfd_pkg::CH_W-1:0]    offset_q;
	logic [sfd_pkg::SCALE_W-1:0] scale_q;
	logic [sfd_pkg::CH_W-1:0]    max_q;

	// Ring control.
	logic [AW-1:0]         widx_q;
	logic [AW-1:0]         widx_nx;
	logic [AW:0]           start_wide;
	logic [AW-1:0]         start_nx;
	logic [RING_DEPTH-1:0] byte_vld_q;
	logic [AW-1:0]         rd_addr_q;
	logic [AW-1:0]         rd_addr_inc;
	logic                  rvld_q;
	logic [RAM_W-1:0]      ram_rdata;
	logic                  ram_we;

	// Sequencer counters and frame data.
	logic [sfd_pkg::BYTE_CNT_W-1:0] byte_cnt_q;
	logic [sfd_pkg::CH_IDX_W-1:0]   ch_q;
	logic [sfd_pkg::STAMP_W-1:0]    stamp_q;
	logic [sfd_pkg::PAYLOAD_W-1:0]  pay_q;
	logic                           fs_q;
	logic [sfd_pkg::PROD_W-1:0]     prod_q;

	// Output register.
	logic                         out_vld_q;
	logic [sfd_pkg::CH_IDX_W-1:0] out_idx_q;
	logic [sfd_pkg::CH_W-1:0]     out_val_q;
	logic                         out_fs_q;
	logic                         out_last_q;

	logic                          in_acc;
	logic                          slot_free;
	logic [sfd_pkg::BYTE_W-1:0]    rd_byte;
	logic [sfd_pkg::STAMP_W-1:0]   rd_stamp;
	logic [sfd_pkg::STAMP_W-1:0]   elapsed;
	logic                          frame_ok;
	logic [sfd_pkg::CH_W-1:0]      raw_ch;
	logic [sfd_pkg::CH_W-1:0]      diff_ch;
	logic [sfd_pkg::PROD_W-FRAC_SH-1:0] scaled;
	logic [sfd_pkg::CH_W-1:0]      sat_ch;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != sfd_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_vld_q || !out_stall;

	// Ring address arithmetic, modulo the ring depth.
	assign widx_nx     = (widx_q == TOP_ADDR) ? '0 : widx_q + 1'b1;
	assign rd_addr_inc = (rd_addr_q == TOP_ADDR) ? '0 : rd_addr_q + 1'b1;
	assign start_wide  = ({1'b0, widx_nx} >= SPAN_W) ? ({1'b0, widx_nx} - SPAN_W)
	                                                 : ({1'b0, widx_nx} + DEPTH_W - SPAN_W);
	assign start_nx    = start_wide[AW-1:0];

	// Byte and millisecond stamp share one ring entry.
	assign ram_we = in_acc && !rx_error;

	sfd_ram #(
		.WIDTH (RAM_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx_nx),
		.wdata ({rx_byte, arrival_ticks[sfd_pkg::STAMP_LSB +: sfd_pkg::STAMP_W]}),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// A slot cleared since its last write reads as 0xFF.
	assign rd_byte  = rvld_q ? ram_rdata[RAM_W-1 -: sfd_pkg::BYTE_W] : 8'hFF;
	assign rd_stamp = ram_rdata[sfd_pkg::STAMP_W-1:0];
	assign elapsed  = stamp_q - rd_stamp;
	assign frame_ok = (rd_byte == sfd_pkg::START_MARK) && (elapsed <= gap_q);

	// Channel arithmetic: offset with floor, then saturation of the scaled product.
	assign raw_ch  = pay_q[sfd_pkg::CH_W-1:0];
	assign diff_ch = (raw_ch > offset_q) ? (raw_ch - offset_q) : '0;
	assign scaled  = prod_q[sfd_pkg::PROD_W-1:FRAC_SH];
	assign sat_ch  = (scaled > {2'b00, max_q}) ? max_q : scaled[sfd_pkg::CH_W-1:0];

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfd_pkg::ST_IDLE: begin
				if (in_acc && !rx_error && rx_byte == sfd_pkg::END_MARK) begin
					state_d = sfd_pkg::ST_RDADDR;
				end
			end
			sfd_pkg::ST_RDADDR: begin
				state_d = sfd_pkg::ST_RDDATA;
			end
			sfd_pkg::ST_RDDATA: begin
				if (byte_cnt_q == '0 && !frame_ok) begin
					state_d = sfd_pkg::ST_IDLE;
				end else if (byte_cnt_q == FS_CNT) begin
					state_d = sfd_pkg::ST_MUL;
				end else begin
					state_d = sfd_pkg::ST_RDADDR;
				end
			end
			sfd_pkg::ST_MUL: begin
				state_d = sfd_pkg::ST_SEND;
			end
			sfd_pkg::ST_SEND: begin
				if (slot_free) begin
					state_d = (ch_q == LAST_CH) ? sfd_pkg::ST_IDLE : sfd_pkg::ST_MUL;
				end
			end
			default: begin
				state_d = sfd_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= sfd_pkg::GAP_RST;
			offset_q <= sfd_pkg::OFFSET_RST;
			scale_q  <= sfd_pkg::SCALE_RST;
			max_q    <= sfd_pkg::MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfd_pkg::CFG_GAP:    gap_q    <= cfg_data[sfd_pkg::GAP_W-1:0];
				sfd_pkg::CFG_OFFSET: offset_q <= cfg_data[sfd_pkg::CH_W-1:0];
				sfd_pkg::CFG_SCALE:  scale_q  <= cfg_data[sfd_pkg::SCALE_W-1:0];
				sfd_pkg::CFG_MAX:    max_q    <= cfg_data[sfd_pkg::CH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Control registers: write index, slot valid bits, counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q     <= '0;
			byte_vld_q <= '0;
			byte_cnt_q <= '0;
			ch_q       <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				if (rx_error) begin
					byte_vld_q <= '0;
				end else begin
					widx_q              <= widx_nx;
					byte_vld_q[widx_nx] <= 1'b1;
				end
				byte_cnt_q <= '0;
				ch_q       <= '0;
			end
			if (state_q == sfd_pkg::ST_RDDATA) begin
				byte_cnt_q <= byte_cnt_q + 1'b1;
			end
			if (state_q == sfd_pkg::ST_SEND && slot_free) begin
				out_vld_q <= 1'b1;
				ch_q      <= ch_q + 1'b1;
				if (ch_q == LAST_CH) begin
					byte_vld_q <= '0;
				end
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Frame datapath: ring read-back, payload shift register, multiplier, output data.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			stamp_q   <= arrival_ticks[sfd_pkg::STAMP_LSB +: sfd_pkg::STAMP_W];
			rd_addr_q <= start_nx;
		end
		if (state_q == sfd_pkg::ST_RDADDR) begin
			rvld_q <= byte_vld_q[rd_addr_q];
		end
		if (state_q == sfd_pkg::ST_RDDATA) begin
			rd_addr_q <= rd_addr_inc;
			if (byte_cnt_q == FS_CNT) begin
				fs_q <= |rd_byte[3:2];
			end else if (byte_cnt_q != '0) begin
				pay_q <= {rd_byte, pay_q[sfd_pkg::PAYLOAD_W-1:sfd_pkg::BYTE_W]};
			end
		end
		if (state_q == sfd_pkg::ST_MUL) begin
			prod_q <= sfd_pkg::PROD_W'(diff_ch) * sfd_pkg::PROD_W'(scale_q);
		end
		if (state_q == sfd_pkg::ST_SEND && slot_free) begin
			out_idx_q  <= ch_q;
			out_val_q  <= sat_ch;
			out_fs_q   <= fs_q;
			out_last_q <= (ch_q == LAST_CH);
			pay_q      <= pay_q >> sfd_pkg::CH_W;
		end
	end

	assign out_valid     = out_vld_q;
	assign channel_index = out_idx_q;
	assign channel_value = out_val_q;
	assign failsafe      = out_fs_q;
	assign last          = out_last_q;

	// An errored byte leaves every ring slot reading as 0xFF.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && rx_error) |=> (byte_vld_q == '0))
		else $error("byte ring not cleared after errored byte");

	// A new output beat is only loaded from the send step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == sfd_pkg::ST_SEND))
		else $error("output valid raised outside send step");

	// The end-of-frame mark travels with the last channel only.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_last_q) |-> (out_idx_q == LAST_CH))
		else $error("last flag on wrong channel");

	// The write index stays inside the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, widx_q} < DEPTH_W))
		else $error("write index outside ring");

	// The ring is cleared after the last channel of a frame is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfd_pkg::ST_SEND && slot_free && ch_q == LAST_CH)
			|=> (byte_vld_q == '0 && state_q == sfd_pkg::ST_IDLE))
		else $error("ring not cleared at frame end");

endmodule
